### hdl/gcd_pkg.sv
`timescale 1ns / 1ps

package gcd_pkg;

   localparam int ANGLE_FRAC_BITS  = 22;
   localparam int LENGTH_FRAC_BITS = 8;
   localparam int CORDIC_STAGES    = 24;
   localparam int TRIG_FRAC        = 30;

   localparam int LAT_W    = 30;
   localparam int LON_W    = 31;
   localparam int RADIUS_W = 24;
   localparam int ARC_W    = 34;

   localparam int HALF_FRAC = ANGLE_FRAC_BITS + 1;
   localparam int ANG_W     = 36;
   localparam int MAG_W     = 31;
   localparam int K_W       = 27;
   localparam int PROD_W    = MAG_W + K_W;
   localparam int CW        = 34;
   localparam int TV_W      = 32;
   localparam int A_W       = TRIG_FRAC + 1;
   localparam int RAD_W     = 2 * TRIG_FRAC + 1;
   localparam int SQ_STEPS  = TRIG_FRAC + 1;
   localparam int ZC_W      = 31;
   localparam int LEN_PROD_W = RADIUS_W + ZC_W + 1;
   localparam int LEN_SHIFT = TRIG_FRAC - LENGTH_FRAC_BITS;
   localparam int LEN_W     = LEN_PROD_W + 1 - LEN_SHIFT;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(6371000);
   localparam logic [K_W-1:0] DEG_TO_RAD_Q32 = K_W'(74961321);
   localparam logic signed [CW-1:0] CORDIC_INV_GAIN = CW'(652032874);

   localparam logic signed [ANG_W-1:0] FULL_TURN    = ANG_W'(64'sd360 <<< HALF_FRAC);
   localparam logic signed [ANG_W-1:0] HALF_TURN    = ANG_W'(64'sd180 <<< HALF_FRAC);
   localparam logic signed [ANG_W-1:0] NEG_HALF     = ANG_W'(-(64'sd180 <<< HALF_FRAC));
   localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(64'sd90 <<< HALF_FRAC);
   localparam logic signed [ANG_W-1:0] NEG_QUARTER  = ANG_W'(-(64'sd90 <<< HALF_FRAC));

   localparam logic [ARC_W-1:0] ARC_MAX = '1;

   localparam logic signed [CW-1:0] ATAN_TABLE [11] = '{
      CW'(843314857), CW'(497837829), CW'(263043837), CW'(133525159),
      CW'(67021687), CW'(33543516), CW'(16775851), CW'(8388437),
      CW'(4194283), CW'(2097149), CW'(1048576)
   };

   function automatic logic signed [CW-1:0] atan_step(input int i);
      logic signed [CW-1:0] r;
      if (i < 11) begin
         r = ATAN_TABLE[i];
      end else begin
         r = CW'((64'sd1 <<< TRIG_FRAC) >>> i);
      end
      return r;
   endfunction

   function automatic logic signed [TV_W-1:0] round_trig(input logic signed [2*TV_W-1:0] p);
      logic signed [2*TV_W-1:0] s;
      s = (p + ((2*TV_W)'(1) <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
      return s[TV_W-1:0];
   endfunction

endpackage

### hdl/great_circle_distance_top.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle while the response is not stalled; the depth is set by the
// two 24-stage CORDIC pipelines and the 31-stage square root pipeline.
// A stalled response holds the whole pipeline in place.
// Reset (synchronous) clears all valid bits and loads the radius with 6371000.
module great_circle_distance_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [gcd_pkg::LAT_W-1:0]    req_first_latitude,
   input  logic signed [gcd_pkg::LON_W-1:0]    req_first_longitude,
   input  logic signed [gcd_pkg::LAT_W-1:0]    req_second_latitude,
   input  logic signed [gcd_pkg::LON_W-1:0]    req_second_longitude,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [gcd_pkg::ARC_W-1:0]    rsp_arc_length,
   input  logic                                csr_wr_en,
   input  logic        [gcd_pkg::RADIUS_W-1:0] csr_wr_data
);
   import gcd_pkg::*;

   localparam int CS     = CORDIC_STAGES;
   localparam int SQ     = SQ_STEPS;
   localparam int DEPTH  = 5 + CS + 5 + SQ + CS + 2;
   localparam int SQ_END = 5 + CS + 4 + SQ;

   logic [DEPTH-1:0] vld_ff, vld_in;
   logic             adv;
   logic [RADIUS_W-1:0] radius_ff;

   assign adv       = !vld_ff[DEPTH-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[DEPTH-1];
   assign vld_in    = {vld_ff[DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         radius_ff <= RADIUS_RESET;
      end else begin
         if (adv) begin
            vld_ff <= vld_in;
         end
         if (csr_wr_en) begin
            radius_ff <= csr_wr_data;
         end
      end
   end

   // angle front end: lanes are dlat/2, dlon/2, lat1, lat2
   logic signed [ANG_W-1:0] ang1_ff [4];
   logic signed [ANG_W-1:0] ang2_ff [4];
   logic [MAG_W-1:0]        mag3_ff [4];
   logic                    neg3_ff [4], flip3_ff [4];
   logic [PROD_W-1:0]       prod4_ff [4];
   logic                    neg4_ff [4], flip4_ff [4];

   logic signed [CW-1:0] cx_ff [4][CS+1];
   logic signed [CW-1:0] cy_ff [4][CS+1];
   logic signed [CW-1:0] cz_ff [4][CS+1];
   logic                 cf_ff [4][CS+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         ang1_ff[0] <= ANG_W'(req_second_latitude) - ANG_W'(req_first_latitude);
         ang1_ff[1] <= ANG_W'(req_second_longitude) - ANG_W'(req_first_longitude);
         ang1_ff[2] <= ANG_W'(req_first_latitude) <<< 1;
         ang1_ff[3] <= ANG_W'(req_second_latitude) <<< 1;
      end
   end

   for (genvar l = 0; l < 4; l++) begin : g_front
      logic signed [ANG_W-1:0] red_in, fold_in, mag_full;
      logic                    flip_in;
      logic [PROD_W-1:0]       zr;

      always_comb begin
         if (ang1_ff[l] >= HALF_TURN) begin
            red_in = ang1_ff[l] - FULL_TURN;
         end else if (ang1_ff[l] < NEG_HALF) begin
            red_in = ang1_ff[l] + FULL_TURN;
         end else begin
            red_in = ang1_ff[l];
         end
         flip_in = 1'b0;
         if (ang2_ff[l] > QUARTER_TURN) begin
            fold_in = HALF_TURN - ang2_ff[l];
            flip_in = 1'b1;
         end else if (ang2_ff[l] < NEG_QUARTER) begin
            fold_in = NEG_HALF - ang2_ff[l];
            flip_in = 1'b1;
         end else begin
            fold_in = ang2_ff[l];
         end
         mag_full = fold_in[ANG_W-1] ? -fold_in : fold_in;
         zr = (prod4_ff[l] + (PROD_W'(1) << (HALF_FRAC + 1))) >> (HALF_FRAC + 2);
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            ang2_ff[l]  <= red_in;
            mag3_ff[l]  <= mag_full[MAG_W-1:0];
            neg3_ff[l]  <= fold_in[ANG_W-1];
            flip3_ff[l] <= flip_in;
            prod4_ff[l] <= PROD_W'(mag3_ff[l]) * PROD_W'(DEG_TO_RAD_Q32);
            neg4_ff[l]  <= neg3_ff[l];
            flip4_ff[l] <= flip3_ff[l];
            cx_ff[l][0] <= CORDIC_INV_GAIN;
            cy_ff[l][0] <= '0;
            cz_ff[l][0] <= neg4_ff[l] ? -CW'(zr) : CW'(zr);
            cf_ff[l][0] <= flip4_ff[l];
         end
      end

      for (genvar s = 0; s < CS; s++) begin : g_rot
         localparam logic signed [CW-1:0] ATAN = atan_step(s);
         logic signed [CW-1:0] dx, dy;
         assign dx = cy_ff[l][s] >>> s;
         assign dy = cx_ff[l][s] >>> s;
         always_ff @(posedge clock) begin
            if (adv) begin
               cf_ff[l][s+1] <= cf_ff[l][s];
               if (!cz_ff[l][s][CW-1]) begin
                  cx_ff[l][s+1] <= cx_ff[l][s] - dx;
                  cy_ff[l][s+1] <= cy_ff[l][s] + dy;
                  cz_ff[l][s+1] <= cz_ff[l][s] - ATAN;
               end else begin
                  cx_ff[l][s+1] <= cx_ff[l][s] + dx;
                  cy_ff[l][s+1] <= cy_ff[l][s] - dy;
                  cz_ff[l][s+1] <= cz_ff[l][s] + ATAN;
               end
            end
         end
      end
   end

   // haversine term
   logic signed [TV_W-1:0]   sl, sn, c1, c2;
   logic signed [2*TV_W-1:0] psl_ff, pcc_ff, psn_ff, p2_ff;
   logic signed [TV_W-1:0]   t1_ff, cc_ff, sq_ff, t1d_ff, t1e_ff, t2_ff;
   logic signed [TV_W+1:0]   hsum, hrest;
   logic [A_W-1:0]           a_in, b_in;
   localparam logic signed [TV_W+1:0] ONE = (TV_W+2)'(1) <<< TRIG_FRAC;

   logic [RAD_W-1:0] sqn_ff [2][SQ+1];
   logic [RAD_W-1:0] sqr_ff [2][SQ+1];

   always_comb begin
      logic signed [CW-1:0] x2, x3;
      x2 = cf_ff[2][CS] ? -cx_ff[2][CS] : cx_ff[2][CS];
      x3 = cf_ff[3][CS] ? -cx_ff[3][CS] : cx_ff[3][CS];
      sl = cy_ff[0][CS][TV_W-1:0];
      sn = cy_ff[1][CS][TV_W-1:0];
      c1 = x2[TV_W-1:0];
      c2 = x3[TV_W-1:0];
      hsum  = (TV_W+2)'(t1e_ff) + (TV_W+2)'(t2_ff);
      hrest = ONE - hsum;
      if (hsum[TV_W+1]) begin
         a_in = '0;
      end else if (hsum > ONE) begin
         a_in = A_W'(ONE);
      end else begin
         a_in = hsum[A_W-1:0];
      end
      if (hrest[TV_W+1]) begin
         b_in = '0;
      end else if (hrest > ONE) begin
         b_in = A_W'(ONE);
      end else begin
         b_in = hrest[A_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         psl_ff <= sl * sl;
         pcc_ff <= c1 * c2;
         psn_ff <= sn * sn;
         t1_ff  <= round_trig(psl_ff);
         cc_ff  <= round_trig(pcc_ff);
         sq_ff  <= round_trig(psn_ff);
         p2_ff  <= cc_ff * sq_ff;
         t1d_ff <= t1_ff;
         t2_ff  <= round_trig(p2_ff);
         t1e_ff <= t1d_ff;
         sqn_ff[0][0] <= {a_in, {TRIG_FRAC{1'b0}}};
         sqn_ff[1][0] <= {b_in, {TRIG_FRAC{1'b0}}};
         sqr_ff[0][0] <= '0;
         sqr_ff[1][0] <= '0;
      end
   end

   // floor square root, one result bit a stage
   for (genvar l = 0; l < 2; l++) begin : g_sqrt
      for (genvar k = 0; k < SQ; k++) begin : g_step
         localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (SQ - 1 - k));
         logic [RAD_W-1:0] trial;
         assign trial = sqr_ff[l][k] + BIT;
         always_ff @(posedge clock) begin
            if (adv) begin
               if (sqn_ff[l][k] >= trial) begin
                  sqn_ff[l][k+1] <= sqn_ff[l][k] - trial;
                  sqr_ff[l][k+1] <= (sqr_ff[l][k] >> 1) + BIT;
               end else begin
                  sqn_ff[l][k+1] <= sqn_ff[l][k];
                  sqr_ff[l][k+1] <= sqr_ff[l][k] >> 1;
               end
            end
         end
      end
   end

   // central angle by vectoring
   logic signed [CW-1:0] vx [CS+1];
   logic signed [CW-1:0] vy [CS+1];
   logic signed [CW-1:0] vz [CS+1];

   assign vx[0] = $signed({{(CW-A_W){1'b0}}, sqr_ff[1][SQ][A_W-1:0]});
   assign vy[0] = $signed({{(CW-A_W){1'b0}}, sqr_ff[0][SQ][A_W-1:0]});
   assign vz[0] = '0;

   for (genvar k = 0; k < CS; k++) begin : g_vec
      localparam logic signed [CW-1:0] ATAN = atan_step(k);
      logic signed [CW-1:0] vx_ff, vy_ff, vz_ff, dx, dy;
      assign dx = vy[k] >>> k;
      assign dy = vx[k] >>> k;
      always_ff @(posedge clock) begin
         if (adv) begin
            if (!vy[k][CW-1]) begin
               vx_ff <= vx[k] + dx;
               vy_ff <= vy[k] - dy;
               vz_ff <= vz[k] + ATAN;
            end else begin
               vx_ff <= vx[k] - dx;
               vy_ff <= vy[k] + dy;
               vz_ff <= vz[k] - ATAN;
            end
         end
      end
      assign vx[k+1] = vx_ff;
      assign vy[k+1] = vy_ff;
      assign vz[k+1] = vz_ff;
   end

   // arc length
   logic [ZC_W-1:0]       zc;
   logic [LEN_PROD_W-1:0] lprod_ff;
   logic [LEN_PROD_W:0]   lsum;
   logic [LEN_W-1:0]      len;
   logic [ARC_W-1:0]      rsp_arc_length_ff;

   always_comb begin
      zc   = vz[CS][CW-1] ? '0 : vz[CS][ZC_W-1:0];
      lsum = (LEN_PROD_W+1)'(lprod_ff) + ((LEN_PROD_W+1)'(1) << (LEN_SHIFT - 1));
      len  = lsum[LEN_PROD_W:LEN_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lprod_ff <= LEN_PROD_W'(radius_ff) * LEN_PROD_W'({zc, 1'b0});
         rsp_arc_length_ff <= (len > LEN_W'(ARC_MAX)) ? ARC_MAX : len[ARC_W-1:0];
      end
   end

   assign rsp_arc_length = rsp_arc_length_ff;

`ifndef SYNTHESIS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff) && $stable(rsp_arc_length))
      else $error("pipeline moved while stalled");

   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] |-> (mag3_ff[0] <= MAG_W'(QUARTER_TURN)) && (mag3_ff[1] <= MAG_W'(QUARTER_TURN)))
      else $error("folded angle beyond a quarter turn");

   a_sqrt_a: assert property (@(posedge clock) disable iff (reset)
      vld_ff[SQ_END] |-> sqn_ff[0][SQ] <= (sqr_ff[0][SQ] << 1))
      else $error("square root of the haversine term not floored");

   a_sqrt_b: assert property (@(posedge clock) disable iff (reset)
      vld_ff[SQ_END] |-> sqn_ff[1][SQ] <= (sqr_ff[1][SQ] << 1))
      else $error("square root of the complement not floored");
`endif

endmodule
